FILE: src/assert_macros.svh
// Assertion macros shared by the checker files of this project.
// Needs nothing else; take it in with a plain include of the file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the active-low reset is asserted.
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("%m: assertion label failed");

// Clocked assertion that also holds while reset is asserted.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("%m: assertion label failed");

`endif

FILE: src/ewsm_pkg.sv
// Package for the encoder window speed meter: widths, register indexes,
// reset values and the configuration struct. Depends on nothing.
`timescale 1ns / 1ps

package ewsm_pkg;

  // Width of the encoder position counter that is actually used.
  localparam int unsigned COUNT_WIDTH = 16;
  // Width in which the count magnitude is compared against the registers.
  localparam int unsigned MAG_WIDTH   = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  localparam int unsigned ENC_WIDTH   = 16;
  localparam int unsigned WIN_WIDTH   = 16;
  localparam int unsigned GAIN_WIDTH  = 32;
  localparam int unsigned SPEED_WIDTH = 48;
  localparam int unsigned CFG_IDX_WIDTH  = 8;
  localparam int unsigned CFG_DATA_WIDTH = 32;

  localparam logic [15:0]           RST_SAMPLE_PERIOD  = 16'd10;
  localparam logic [15:0]           RST_COUNTS_PER_REV = 16'd1000;
  localparam logic [15:0]           RST_COUNTER_PERIOD = 16'd1000;
  localparam logic [GAIN_WIDTH-1:0] RST_SPEED_GAIN     = 32'd393216;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_SAMPLE_PERIOD  = 8'd0,
    CFG_COUNTS_PER_REV = 8'd1,
    CFG_COUNTER_PERIOD = 8'd2,
    CFG_SPEED_GAIN     = 8'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0]           sample_period;
    logic [15:0]           counts_per_rev;
    logic [15:0]           counter_period;
    logic [GAIN_WIDTH-1:0] speed_gain;
  } cfg_t;

  typedef logic [COUNT_WIDTH-1:0] count_t;

endpackage

FILE: src/ewsm_cfg.sv
// Configuration register file of the encoder window speed meter.
// Depends on ewsm_pkg.
`timescale 1ns / 1ps

module ewsm_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic [ewsm_pkg::CFG_IDX_WIDTH-1:0]   cfg_index_i,
  input  logic [ewsm_pkg::CFG_DATA_WIDTH-1:0]  cfg_data_i,
  output ewsm_pkg::cfg_t                       cfg_o
);

  ewsm_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (ewsm_pkg::cfg_idx_e'(cfg_index_i))
        ewsm_pkg::CFG_SAMPLE_PERIOD:  cfg_d.sample_period  = cfg_data_i[15:0];
        ewsm_pkg::CFG_COUNTS_PER_REV: cfg_d.counts_per_rev = cfg_data_i[15:0];
        ewsm_pkg::CFG_COUNTER_PERIOD: cfg_d.counter_period = cfg_data_i[15:0];
        ewsm_pkg::CFG_SPEED_GAIN:
          cfg_d.speed_gain = cfg_data_i[ewsm_pkg::GAIN_WIDTH-1:0];
        default: cfg_d = cfg_q;  // Writes beyond the register list are dropped.
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_period  <= ewsm_pkg::RST_SAMPLE_PERIOD;
      cfg_q.counts_per_rev <= ewsm_pkg::RST_COUNTS_PER_REV;
      cfg_q.counter_period <= ewsm_pkg::RST_COUNTER_PERIOD;
      cfg_q.speed_gain     <= ewsm_pkg::RST_SPEED_GAIN;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/ewsm_window.sv
// Tick countdown and snapshot registers of the encoder window speed meter.
// Flags the tick that ends a measurement window. Depends on ewsm_pkg.
`timescale 1ns / 1ps

module ewsm_window (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  logic                              in_valid_i,
  input  logic [ewsm_pkg::ENC_WIDTH-1:0]    encoder_count_i,
  input  logic [15:0]                       sample_period_i,
  output logic                              win_valid_o,
  output ewsm_pkg::count_t                  earlier_o,
  output ewsm_pkg::count_t                  latest_o
);

  logic [15:0]      countdown_q, countdown_d;
  ewsm_pkg::count_t earlier_q, earlier_d;
  ewsm_pkg::count_t latest_q, latest_d;
  logic             win_valid_q, win_valid_d;
  logic             accept;
  logic             win_end;

  assign accept  = in_valid_i && adv_i;
  // A countdown of zero or one closes the window on this tick.
  assign win_end = (countdown_q <= 16'd1);

  always_comb begin
    countdown_d = countdown_q;
    earlier_d   = earlier_q;
    latest_d    = latest_q;
    win_valid_d = win_valid_q;
    if (adv_i) begin
      win_valid_d = accept && win_end;
    end
    if (accept) begin
      if (win_end) begin
        earlier_d   = latest_q;
        latest_d    = ewsm_pkg::COUNT_WIDTH'(encoder_count_i);
        countdown_d = sample_period_i;
      end else begin
        countdown_d = countdown_q - 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      countdown_q <= ewsm_pkg::RST_SAMPLE_PERIOD;
      earlier_q   <= '0;
      latest_q    <= '0;
      win_valid_q <= 1'b0;
    end else begin
      countdown_q <= countdown_d;
      earlier_q   <= earlier_d;
      latest_q    <= latest_d;
      win_valid_q <= win_valid_d;
    end
  end

  assign win_valid_o = win_valid_q;
  assign earlier_o   = earlier_q;
  assign latest_o    = latest_q;

endmodule

FILE: src/ewsm_speed.sv
// Wrap correction and gain multiply of the encoder window speed meter,
// computed from the snapshot registers straight into the result register.
// Depends on ewsm_pkg.
`timescale 1ns / 1ps

module ewsm_speed (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  logic                                win_valid_i,
  input  ewsm_pkg::count_t                    earlier_i,
  input  ewsm_pkg::count_t                    latest_i,
  input  ewsm_pkg::cfg_t                      cfg_i,
  output logic                                out_valid_o,
  output logic [ewsm_pkg::SPEED_WIDTH-1:0]    speed_o,
  output logic [ewsm_pkg::WIN_WIDTH-1:0]      counts_o
);

  localparam int unsigned MW = ewsm_pkg::MAG_WIDTH;

  ewsm_pkg::count_t                  mag;
  logic [MW-1:0]                     mag_w, half_w, period_w, corr_w;
  logic [ewsm_pkg::WIN_WIDTH-1:0]    corr;

  logic                              out_valid_q;
  logic [ewsm_pkg::SPEED_WIDTH-1:0]  speed_q;
  logic [ewsm_pkg::WIN_WIDTH-1:0]    counts_q;

  always_comb begin
    mag      = (latest_i >= earlier_i) ? (latest_i - earlier_i) : (earlier_i - latest_i);
    mag_w    = MW'(mag);
    half_w   = MW'(cfg_i.counts_per_rev >> 1);
    period_w = MW'(cfg_i.counter_period);
    corr_w   = mag_w;
    // More than half a revolution means the counter wrapped in between.
    if (mag_w > half_w) begin
      corr_w = (period_w >= mag_w) ? (period_w - mag_w) : '0;
    end
    if (corr_w > MW'(16'hFFFF)) begin
      corr = 16'hFFFF;
    end else begin
      corr = corr_w[ewsm_pkg::WIN_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      out_valid_q <= win_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      counts_q <= corr;
      speed_q  <= ewsm_pkg::SPEED_WIDTH'(corr) * ewsm_pkg::SPEED_WIDTH'(cfg_i.speed_gain);
    end
  end

  assign out_valid_o = out_valid_q;
  assign speed_o     = speed_q;
  assign counts_o    = counts_q;

endmodule

FILE: src/encoder_window_speed_meter.sv
// Top level of the encoder window speed meter (M-method speed measurement).
// Depends on ewsm_pkg, ewsm_cfg, ewsm_window and ewsm_speed.
//
// Usage:
//   The slave stream carries one tick request per beat; tdata holds the
//   current encoder counter value. Every sample_period ticks a window closes
//   and one result request leaves on the master stream; tdata holds the speed
//   in RPM (unsigned Q32.16) in the low 48 bits and the wrap-corrected count
//   of the window in the upper 16 bits. Ticks inside a window give no result.
//   The configuration channel writes one register per request and is always
//   ready; write only while the block is idle.
//   Pipeline: the countdown register moves at the edge that accepts a tick,
//   and the snapshot registers load at the edge that accepts a closing
//   tick; wrap correction and the multiply then feed the result register
//   when the pipeline advances. Throughput: one tick per cycle while not held.
//   Stalls: the two stages move together; when a result waits in the output
//   register and the receiver holds tready low, the whole pipeline holds and
//   s_axis_tready drops in the same cycle, so nothing is lost or repeated.
//   Reset: registers return to their reset values, the countdown reloads to
//   ten, both snapshots clear and the pipeline empties.
`timescale 1ns / 1ps

module encoder_window_speed_meter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Tick stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] encoder_count
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [47:0] speed_rpm_q16, [63:48] window_counts
  // Configuration writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  ewsm_pkg::cfg_t   cfg;
  logic             adv;
  logic             win_valid;
  ewsm_pkg::count_t earlier;
  ewsm_pkg::count_t latest;
  logic             out_valid;
  logic [47:0]      speed;
  logic [15:0]      counts;

  // The pipeline advances whenever the result register is empty or is
  // being taken in this cycle.
  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready_o   = 1'b1;

  ewsm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ewsm_window u_window (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .in_valid_i      (s_axis_tvalid),
    .encoder_count_i (s_axis_tdata),
    .sample_period_i (cfg.sample_period),
    .win_valid_o     (win_valid),
    .earlier_o       (earlier),
    .latest_o        (latest)
  );

  ewsm_speed u_speed (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .win_valid_i (win_valid),
    .earlier_i   (earlier),
    .latest_i    (latest),
    .cfg_i       (cfg),
    .out_valid_o (out_valid),
    .speed_o     (speed),
    .counts_o    (counts)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {counts, speed};

endmodule

FILE: src/ewsm_checker.sv
// Port-level checker for the encoder window speed meter, bound to the top.
// Depends on assert_macros.svh and encoder_window_speed_meter.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ewsm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  // A stalled result holds its value until it is taken.
  `ASSERT_RST(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
  // Ticks are taken exactly when the result side can move.
  `ASSERT_RST(a_in_ready, clk_i, rst_ni, s_axis_tready == (!m_axis_tvalid || m_axis_tready))
  // A window with no counts reports zero speed.
  `ASSERT_RST(a_zero_speed, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[63:48] == 16'd0) |-> (m_axis_tdata[47:0] == 48'd0))
  // A clock edge under reset leaves no result showing.
  `ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> !m_axis_tvalid)

endmodule

bind encoder_window_speed_meter ewsm_checker u_ewsm_checker (.*);
